// ----- design/pbf_pkg.sv -----
package pbf_pkg;

	localparam int STORE_BYTES    = 1024;
	localparam int MAX_FIELD_BITS = 64;
	localparam int TOTAL_BITS     = STORE_BYTES * 8;
	localparam int ADDR_W         = $clog2(STORE_BYTES);

	localparam int OP_W  = 2;
	localparam int POS_W = 13;
	localparam int FW_W  = 7;
	localparam int VAL_W = 64;

	localparam int SUM_MIN_W = POS_W + 1;
	localparam int SUM_W     = ($clog2(TOTAL_BITS + 1) > SUM_MIN_W) ?
		$clog2(TOTAL_BITS + 1) : SUM_MIN_W;

	localparam logic [OP_W-1:0] OP_RD_ZERO = 2'd0;
	localparam logic [OP_W-1:0] OP_RD_SIGN = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	localparam logic [7:0] BYTE_TOP_BIT = 8'h80;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic       load;
		logic       rd_step;
		logic       wr_step;
		logic       first_byte;
		logic       sext;
		logic [2:0] lo;
		logic [3:0] hi;
	} dig_ctl_t;

endpackage

// ----- design/pbf_ram.sv -----
module pbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/pbf_digit.sv -----
module pbf_digit (
	input  logic                      clk,
	input  pbf_pkg::dig_ctl_t         ctl,
	input  logic [pbf_pkg::VAL_W-1:0] write_value,
	input  logic [7:0]                rdata,
	output logic [pbf_pkg::VAL_W-1:0] rv,
	output logic [7:0]                wdata
);
	import pbf_pkg::*;

	logic [VAL_W-1:0] rv_q;
	logic [VAL_W-1:0] wv_q;
	logic [VAL_W-1:0] rv_base;
	logic [VAL_W-1:0] rv_next;
	logic [3:0]       k;
	logic [2:0]       sh;
	logic [7:0]       mask;
	logic [7:0]       wmask;
	logic             sign;

	// One byte of the store per step: k field bits sit in this byte, ending sh bits above bit 0.
	always_comb begin
		k       = ctl.hi - {1'b0, ctl.lo};
		sh      = 3'(4'd8 - ctl.hi);
		mask    = 8'((9'd1 << k) - 9'd1);
		wmask   = mask << sh;
		sign    = (rdata & (BYTE_TOP_BIT >> ctl.lo)) != 8'd0;
		rv_base = ctl.first_byte ? {VAL_W{ctl.sext & sign}} : rv_q;
		rv_next = (rv_base << k) | VAL_W'((rdata >> sh) & mask);
		wdata   = (rdata & ~wmask) | ((wv_q[7:0] << sh) & wmask);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rv_q <= '0;
			wv_q <= write_value;
		end else begin
			if (ctl.rd_step) begin
				rv_q <= rv_next;
			end
			if (ctl.wr_step) begin
				wv_q <= wv_q >> k;
			end
		end
	end

	assign rv = rv_q;

endmodule

// ----- design/packed_bit_field_store.sv -----
// Bit-addressed field store over a byte-wide RAM, bit 0 being the top bit of byte 0. Each transfer
// reads or writes one field of up to 64 bits; a write walks its bytes from last to first, a read
// from first to last, each byte read in ST_RD and then merged in ST_MOD. The registered read of
// the byte RAM puts the ST_RD state ahead of each byte merge. An empty, unused or out-of-range
// item skips the RAM and goes straight to ST_DONE. A result moves from ST_DONE to the output
// register once that register is free, and only then does in_ready rise for the next item. After
// reset the block clears the store, one byte per cycle, and holds in_ready low until every byte
// is cleared. The next item is accepted while a finished result still waits in the output
// register.
module packed_bit_field_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [pbf_pkg::OP_W-1:0]  op,
	input  logic [pbf_pkg::POS_W-1:0] bit_pos,
	input  logic [pbf_pkg::FW_W-1:0]  field_width,
	input  logic [pbf_pkg::VAL_W-1:0] write_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pbf_pkg::VAL_W-1:0] read_value,
	output logic                      range_error
);
	import pbf_pkg::*;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	addr_t            cur_q;
	addr_t            b0_q;
	addr_t            bend_q;
	logic [2:0]       s_q;
	logic [3:0]       eo_q;
	logic             wr_q;
	logic             sext_q;
	logic             err_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] rv_out_q;
	logic             err_out_q;

	logic [FW_W-1:0]  w_sat;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] end_bit;
	logic             err;
	logic             active;
	logic             accept;
	logic             at_first;
	logic             at_last_byte;
	logic             last;
	logic             out_free;
	dig_ctl_t         ctl;
	logic             ram_we;
	addr_t            ram_waddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;
	logic [7:0]       merged;
	logic [VAL_W-1:0] rv;

	always_comb begin
		w_sat   = (field_width > FW_W'(MAX_FIELD_BITS)) ? FW_W'(MAX_FIELD_BITS) : field_width;
		sum     = SUM_W'(bit_pos) + SUM_W'(w_sat);
		end_bit = sum - SUM_W'(1);
		err     = (op != OP_NONE) && (w_sat != '0) && (sum > SUM_W'(TOTAL_BITS));
		active  = (op != OP_NONE) && (w_sat != '0) && !err;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign at_first     = (cur_q == b0_q);
	assign at_last_byte = (cur_q == bend_q);
	assign last         = wr_q ? at_first : at_last_byte;

	always_comb begin
		ctl.load       = accept;
		ctl.rd_step    = (state_q == ST_MOD) && !wr_q;
		ctl.wr_step    = (state_q == ST_MOD) && wr_q;
		ctl.first_byte = at_first;
		ctl.sext       = sext_q;
		ctl.lo         = at_first ? s_q : 3'd0;
		ctl.hi         = at_last_byte ? eo_q : 4'd8;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = merged;
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_wdata = 8'd0;
		end else if (state_q == ST_MOD && wr_q) begin
			ram_we = 1'b1;
		end
	end

	pbf_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cur_q),
		.rdata(ram_rdata)
	);

	pbf_digit u_digit (
		.clk        (clk),
		.ctl        (ctl),
		.write_value(write_value),
		.rdata      (ram_rdata),
		.rv         (rv),
		.wdata      (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cur_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					cur_q <= cur_q + addr_t'(1);
					if (cur_q == addr_t'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cur_q   <= (op == OP_WRITE) ? addr_t'(end_bit >> 3) : addr_t'(bit_pos >> 3);
						state_q <= active ? ST_RD : ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (last) begin
						state_q <= ST_DONE;
					end else begin
						cur_q   <= wr_q ? cur_q - addr_t'(1) : cur_q + addr_t'(1);
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b0_q   <= addr_t'(bit_pos >> 3);
			bend_q <= addr_t'(end_bit >> 3);
			s_q    <= bit_pos[2:0];
			eo_q   <= {1'b0, end_bit[2:0]} + 4'd1;
			wr_q   <= (op == OP_WRITE);
			sext_q <= (op == OP_RD_SIGN);
			err_q  <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rv_out_q  <= rv;
			err_out_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = rv_out_q;
	assign range_error = err_out_q;

endmodule

// ----- design/pbf_checker.sv -----
module pbf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [pbf_pkg::VAL_W-1:0] read_value,
	input logic                      range_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(range_error))
		else $error("Stalled result changed before its transfer.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> read_value == '0)
		else $error("Range error came with a nonzero read value.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input ready stayed high right after a transfer.");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("Result appeared without preceding work.");

endmodule

bind packed_bit_field_store pbf_checker u_pbf_checker (.*);

// ----- tb/packed_bit_field_store_test.sv -----
module packed_bit_field_store_test;
	import pbf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_AT_RESULT = 150;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 730;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [FW_W-1:0]  width;
		logic [VAL_W-1:0] data;
		int unsigned      gap_after;
	} field_access_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             range_error;
	} field_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op = OP_RD_ZERO;
	logic [POS_W-1:0]    bit_pos = '0;
	logic [FW_W-1:0]     field_width = '0;
	logic [VAL_W-1:0]    write_value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VAL_W-1:0]    read_value;
	logic                range_error;

	field_access_t pending_fields[$];
	field_result_t expected_reads[$];
	logic [7:0]    shadow_bytes[STORE_BYTES];

	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned writes_done = 0;
	int unsigned reads_done = 0;
	int unsigned errors_predicted = 0;
	int unsigned idle_cycles = 0;

	packed_bit_field_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.bit_pos(bit_pos),
		.field_width(field_width),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.range_error(range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic field_result_t access_store(field_access_t acc);
		field_result_t res;
		int unsigned   w;
		int unsigned   p;
		int unsigned   b;
		logic [VAL_W-1:0] bits;
		res = '0;
		w = (acc.width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : acc.width;
		p = acc.pos;
		bits = '0;
		if (acc.op != OP_NONE && w != 0) begin
			if (p + w > TOTAL_BITS) begin
				res.range_error = 1'b1;
				errors_predicted++;
			end else if (acc.op == OP_WRITE) begin
				for (int unsigned i = 0; i < w; i++) begin
					b = p + i;
					shadow_bytes[b >> 3][7 - (b & 7)] = acc.data[w - 1 - i];
				end
				writes_done++;
			end else begin
				for (int unsigned i = 0; i < w; i++) begin
					b = p + i;
					bits = {bits[VAL_W-2:0], shadow_bytes[b >> 3][7 - (b & 7)]};
				end
				if (acc.op == OP_RD_SIGN && w < VAL_W && bits[w - 1])
					bits = bits | ({VAL_W{1'b1}} << w);
				res.read_value = bits;
				reads_done++;
			end
		end
		return res;
	endfunction

	function automatic int unsigned sender_gap();
		if ((items_queued / 100) % 3 == 1)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	task automatic queue_access(logic [OP_W-1:0] o, int unsigned p, int unsigned w,
			logic [VAL_W-1:0] d);
		field_access_t acc;
		acc.op = o;
		acc.pos = p[POS_W-1:0];
		acc.width = w[FW_W-1:0];
		acc.data = d;
		acc.gap_after = sender_gap();
		pending_fields.push_back(acc);
		items_queued++;
	endtask

	task automatic queue_random();
		int unsigned p;
		int unsigned w;
		int unsigned sel;
		logic [OP_W-1:0]  o;
		logic [VAL_W-1:0] d;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			p = $urandom_range(0, 191);
		else if (sel < 8)
			p = TOTAL_BITS - 80 + $urandom_range(0, 79);
		else
			p = $urandom_range(0, TOTAL_BITS - 1);
		sel = $urandom_range(0, 19);
		if (sel == 0)
			w = 0;
		else if (sel == 1)
			w = $urandom_range(MAX_FIELD_BITS + 1, 127);
		else if (sel == 2)
			w = MAX_FIELD_BITS;
		else
			w = $urandom_range(1, MAX_FIELD_BITS);
		d = ($urandom_range(0, 9) == 0) ? {VAL_W{1'b1}} : {$urandom, $urandom};
		if ($urandom_range(0, 2) == 0) begin
			queue_access(OP_WRITE, p, w, d);
			o = $urandom_range(0, 1) ? OP_RD_SIGN : OP_RD_ZERO;
			p = p + $urandom_range(0, 6);
			if (p >= TOTAL_BITS)
				p = TOTAL_BITS - 1;
			queue_access(o, p, w, {$urandom, $urandom});
		end else begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				o = OP_NONE;
			else if (sel < 9)
				o = OP_WRITE;
			else if (sel < 15)
				o = OP_RD_ZERO;
			else
				o = OP_RD_SIGN;
			queue_access(o, p, w, d);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : sender
		field_access_t current;
		int unsigned   gap_left;
		logic          offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				expected_reads.push_back(access_store(current));
				items_accepted++;
				gap_left = current.gap_after;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_fields.size() != 0) begin
					current = pending_fields.pop_front();
					op <= current.op;
					bit_pos <= current.pos;
					field_width <= current.width;
					write_value <= current.data;
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		field_result_t want;
		int unsigned   stall_left;
		int unsigned   hold_left;
		logic          take;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reads.size() == 0) begin
					$display("%0t: unexpected result read_value %h range_error %b",
						$time, read_value, range_error);
					mismatches++;
				end else begin
					want = expected_reads.pop_front();
					if (read_value !== want.read_value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, read_value);
						mismatches++;
					end
					if (range_error !== want.range_error) begin
						$display("%0t: range_error expected %b actual %b",
							$time, want.range_error, range_error);
						mismatches++;
					end
				end
				results_seen++;
				stall_left = ((results_seen / 120) % 3 == 0) ? 0 : $urandom_range(0, 16);
				if (results_seen == HOLD_AT_RESULT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			out_ready <= take;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d of %0d items accepted",
				$time, idle_cycles, items_accepted, items_queued);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		foreach (shadow_bytes[i])
			shadow_bytes[i] = 8'h00;

		queue_access(OP_RD_ZERO, 0, MAX_FIELD_BITS, '0);
		queue_access(OP_WRITE, 0, MAX_FIELD_BITS, 64'hF0E1_D2C3_B4A5_9687);
		queue_access(OP_RD_ZERO, 0, MAX_FIELD_BITS, '0);
		queue_access(OP_RD_SIGN, 0, MAX_FIELD_BITS, '0);
		queue_access(OP_RD_SIGN, 5, 13, '0);
		queue_access(OP_WRITE, 7, 9, 64'h0000_0000_0000_0155);
		queue_access(OP_RD_ZERO, 3, 20, '0);
		queue_access(OP_WRITE, TOTAL_BITS - 1, 1, 64'h1);
		queue_access(OP_RD_ZERO, TOTAL_BITS - 1, 1, '0);
		queue_access(OP_RD_SIGN, TOTAL_BITS - 1, 1, '0);
		queue_access(OP_WRITE, TOTAL_BITS - 1, 0, {VAL_W{1'b1}});
		queue_access(OP_RD_SIGN, TOTAL_BITS - 1, 0, '0);
		queue_access(OP_WRITE, TOTAL_BITS - MAX_FIELD_BITS, MAX_FIELD_BITS,
			64'h8000_0000_0000_0001);
		queue_access(OP_RD_SIGN, TOTAL_BITS - MAX_FIELD_BITS, MAX_FIELD_BITS, '0);
		queue_access(OP_WRITE, TOTAL_BITS - MAX_FIELD_BITS + 1, MAX_FIELD_BITS,
			{VAL_W{1'b1}});
		queue_access(OP_RD_ZERO, TOTAL_BITS - 1, 2, '0);
		queue_access(OP_RD_SIGN, TOTAL_BITS - 1, 127, '0);
		queue_access(OP_WRITE, 3, 127, 64'h0123_4567_89AB_CDEF);
		queue_access(OP_RD_SIGN, 3, 100, '0);
		queue_access(OP_NONE, 0, MAX_FIELD_BITS, {VAL_W{1'b1}});
		queue_access(OP_RD_ZERO, 0, MAX_FIELD_BITS, '0);
		while (items_queued < RANDOM_ITEMS + 20)
			queue_random();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_queued)
			@(posedge clk);
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d field accesses and checked %0d results:", items_accepted,
			results_seen);
		$display("%0d writes, %0d reads, %0d out-of-range fields.", writes_done, reads_done,
			errors_predicted);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
design/pbf_pkg.sv
design/pbf_ram.sv
design/pbf_digit.sv
design/packed_bit_field_store.sv
design/pbf_checker.sv
tb/packed_bit_field_store_test.sv
